[src/krt_pkg.sv]
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and codes of the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

    localparam int CAPACITY = 64;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);

    localparam logic [2:0] FUNC_INSERT = 3'd0;
    localparam logic [2:0] FUNC_UPDATE = 3'd1;
    localparam logic [2:0] FUNC_REMOVE = 3'd2;
    localparam logic [2:0] FUNC_LOOKUP = 3'd3;
    localparam logic [2:0] FUNC_LIST   = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOTFOUND = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic [19:0] key;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [13:0] credits;
    } t_rec;

endpackage

[src/keyed_record_table_unit.sv]
// ----------------------------------------------------------------------------
// keyed_record_table_unit
// Record table with linear key search and listing in ascending key order.
// ----------------------------------------------------------------------------
// Channel  | direction | handshake          | payload
// request  | in        | i_valid / o_ready  | i_func i_key i_day i_month i_year i_credits
// result   | out       | o_valid / i_ready  | o_status o_rec_* o_last
//
// Search: each stored entry is read (S_RD) and then compared (S_CMP), one memory read port.
// List: one full table walk per result item.
// Request is taken only when the block is idle; a stalled result holds everything.
// Reset clears the count and control; the record memory is never cleared.
// ----------------------------------------------------------------------------
module keyed_record_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_func,
    input  logic [19:0] i_key,
    input  logic [4:0]  i_day,
    input  logic [3:0]  i_month,
    input  logic [13:0] i_year,
    input  logic [13:0] i_credits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [19:0] o_rec_key,
    output logic [4:0]  o_rec_day,
    output logic [3:0]  o_rec_month,
    output logic [13:0] o_rec_year,
    output logic [13:0] o_rec_credits,
    output logic        o_last
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_MISS = 3'd3;
    localparam logic [2:0] S_RDL  = 3'd4;
    localparam logic [2:0] S_CMPL = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    krt_pkg::t_rec r_mem [krt_pkg::CAPACITY];
    krt_pkg::t_rec r_rd;
    krt_pkg::t_rec r_in;
    krt_pkg::t_rec r_best;
    krt_pkg::t_rec r_orec;

    logic [2:0]              r_state;
    logic [2:0]              r_func;
    logic [krt_pkg::CW-1:0]  r_count;
    logic [krt_pkg::CW-1:0]  r_nout;
    logic [krt_pkg::AW-1:0]  r_idx;
    logic [krt_pkg::AW-1:0]  r_hit;
    logic [19:0]             r_prev;
    logic                    r_has_prev;
    logic                    r_has_best;
    logic                    r_ovalid;
    logic [2:0]              r_ostatus;
    logic                    r_olast;

    logic [krt_pkg::CW-1:0]  idx_inc;
    logic [krt_pkg::CW-1:0]  count_m1;
    logic [krt_pkg::AW-1:0]  raddr;
    logic                    at_end;
    logic                    key_hit;
    logic                    cand;
    logic                    we;
    logic [krt_pkg::AW-1:0]  waddr;
    krt_pkg::t_rec           wdata;
    krt_pkg::t_rec           in_rec;
    krt_pkg::t_rec           pick;

    assign in_rec   = '{key: i_key, day: i_day, month: i_month, year: i_year,
                        credits: i_credits};
    assign idx_inc  = {1'b0, r_idx} + krt_pkg::CW'(1);
    assign count_m1 = r_count - krt_pkg::CW'(1);
    assign at_end   = (idx_inc == r_count);
    assign key_hit  = (r_rd.key == r_in.key);
    assign cand     = (!r_has_prev || r_rd.key > r_prev)
                   && (!r_has_best || r_rd.key < r_best.key);
    assign pick     = cand ? r_rd : r_best;
    assign raddr    = (r_state == S_RDL) ? count_m1[krt_pkg::AW-1:0] : r_idx;

    // memory write port
    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = r_in;
        if (r_state == S_MISS && r_func == krt_pkg::FUNC_INSERT) begin
            we    = 1'b1;
            waddr = r_count[krt_pkg::AW-1:0];
        end else if (r_state == S_CMP && r_func == krt_pkg::FUNC_UPDATE && key_hit) begin
            we        = 1'b1;
            wdata.key = r_rd.key;
        end else if (r_state == S_CMPL) begin
            we    = 1'b1;
            waddr = r_hit;
            wdata = r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_ovalid   <= 1'b0;
            r_has_prev <= 1'b0;
            r_has_best <= 1'b0;
            r_nout     <= '0;
            r_idx      <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_func     <= i_func;
                        r_in       <= in_rec;
                        r_idx      <= '0;
                        r_has_prev <= 1'b0;
                        r_has_best <= 1'b0;
                        r_nout     <= '0;
                        r_orec     <= '0;
                        r_olast    <= 1'b1;
                        if (i_func > krt_pkg::FUNC_LIST) begin
                            r_state <= S_IDLE;
                        end else if (i_func == krt_pkg::FUNC_INSERT
                                     && r_count == krt_pkg::CW'(krt_pkg::CAPACITY)) begin
                            r_ostatus <= krt_pkg::ST_FULL;
                            r_ovalid  <= 1'b1;
                            r_state   <= S_OUT;
                        end else if (r_count == '0) begin
                            if (i_func == krt_pkg::FUNC_LIST) begin
                                r_ostatus <= krt_pkg::ST_EMPTY;
                                r_ovalid  <= 1'b1;
                                r_state   <= S_OUT;
                            end else begin
                                r_state <= S_MISS;
                            end
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_func == krt_pkg::FUNC_LIST) begin
                        if (cand) begin
                            r_best     <= r_rd;
                            r_has_best <= 1'b1;
                        end
                        if (at_end) begin
                            r_orec     <= pick;
                            r_prev     <= pick.key;
                            r_has_prev <= 1'b1;
                            r_ostatus  <= krt_pkg::ST_OK;
                            r_olast    <= (r_nout + krt_pkg::CW'(1) == r_count);
                            r_nout     <= r_nout + krt_pkg::CW'(1);
                            r_ovalid   <= 1'b1;
                            r_state    <= S_OUT;
                        end else begin
                            r_idx   <= r_idx + krt_pkg::AW'(1);
                            r_state <= S_RD;
                        end
                    end else if (key_hit) begin
                        r_hit <= r_idx;
                        unique case (r_func)
                            krt_pkg::FUNC_INSERT: begin
                                r_ostatus <= krt_pkg::ST_DUP;
                                r_ovalid  <= 1'b1;
                                r_state   <= S_OUT;
                            end
                            krt_pkg::FUNC_REMOVE: begin
                                r_ostatus <= krt_pkg::ST_OK;
                                if (at_end) begin
                                    r_count  <= count_m1;
                                    r_ovalid <= 1'b1;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_state <= S_RDL;
                                end
                            end
                            krt_pkg::FUNC_LOOKUP: begin
                                r_ostatus <= krt_pkg::ST_OK;
                                r_orec    <= r_rd;
                                r_ovalid  <= 1'b1;
                                r_state   <= S_OUT;
                            end
                            default: begin
                                r_ostatus <= krt_pkg::ST_OK;
                                r_ovalid  <= 1'b1;
                                r_state   <= S_OUT;
                            end
                        endcase
                    end else if (at_end) begin
                        r_state <= S_MISS;
                    end else begin
                        r_idx   <= r_idx + krt_pkg::AW'(1);
                        r_state <= S_RD;
                    end
                end
                S_MISS: begin
                    if (r_func == krt_pkg::FUNC_INSERT) begin
                        r_count   <= r_count + krt_pkg::CW'(1);
                        r_ostatus <= krt_pkg::ST_OK;
                    end else begin
                        r_ostatus <= krt_pkg::ST_NOTFOUND;
                    end
                    r_ovalid <= 1'b1;
                    r_state  <= S_OUT;
                end
                S_RDL: begin
                    r_state <= S_CMPL;
                end
                S_CMPL: begin
                    // last entry moves into the freed slot
                    r_count  <= count_m1;
                    r_ovalid <= 1'b1;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_ovalid <= 1'b0;
                        if (r_func == krt_pkg::FUNC_LIST && !r_olast) begin
                            r_idx      <= '0;
                            r_has_best <= 1'b0;
                            r_state    <= S_RD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_rec_key     = r_orec.key;
    assign o_rec_day     = r_orec.day;
    assign o_rec_month   = r_orec.month;
    assign o_rec_year    = r_orec.year;
    assign o_rec_credits = r_orec.credits;
    assign o_last        = r_olast;

endmodule

[src/krt_checker.sv]
// ----------------------------------------------------------------------------
// krt_checker
// Port-level checks of the keyed record table.
// ----------------------------------------------------------------------------
module krt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_status,
    input logic [19:0] o_rec_key,
    input logic [13:0] o_rec_credits,
    input logic        o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_rec_key)
            && $stable(o_last))
        else $error("result item changed while stalled");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("request taken while a result item is pending");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != krt_pkg::ST_OK |-> o_last)
        else $error("error item not marked last");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != krt_pkg::ST_OK |-> o_rec_key == '0 && o_rec_credits == '0)
        else $error("error item carries record data");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind keyed_record_table_unit krt_checker u_krt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_status      (o_status),
    .o_rec_key     (o_rec_key),
    .o_rec_credits (o_rec_credits),
    .o_last        (o_last)
);

[test/tb_keyed_record_table_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyed_record_table_unit
// Directed requests from a stimulus table, then a random mix of requests that
// fills the table to capacity and churns it. Each result item is compared
// field by field with the oldest entry of a queue fed by a behavioural copy
// of the table or by a row's own expected result; both channels stall at random.
// ----------------------------------------------------------------------------
module tb_keyed_record_table_unit;

    typedef struct packed {
        logic [2:0]    status;
        krt_pkg::t_rec rec;
        logic          last;
    } t_res;

    typedef struct {
        logic [2:0]  func;
        logic [19:0] key;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [13:0] credits;
        bit          typed;
        t_res        res;
    } t_row;

    localparam int            TAIL_CYCLES   = 300;
    localparam int            RANDOM_ITEMS  = 100;
    localparam int            HOLD_CYCLES   = 400;
    localparam krt_pkg::t_rec NO_REC        = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_func;
    logic [19:0] i_key;
    logic [4:0]  i_day;
    logic [3:0]  i_month;
    logic [13:0] i_year;
    logic [13:0] i_credits;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_status;
    logic [19:0] o_rec_key;
    logic [4:0]  o_rec_day;
    logic [3:0]  o_rec_month;
    logic [13:0] o_rec_year;
    logic [13:0] o_rec_credits;
    logic        o_last;

    keyed_record_table_unit dut (.*);

    always #6 i_clk = ~i_clk;

    // Behavioural copy of the table
    krt_pkg::t_rec shadow_tbl[krt_pkg::CAPACITY];
    int   shadow_cnt;
    t_res pending_results[$];
    t_row stim_rows[$];
    int   error_count;
    int   result_count;
    bit   reset_done;

    function automatic int shadow_find(logic [19:0] key);
        for (int i = 0; i < shadow_cnt; i++)
            if (shadow_tbl[i].key == key)
                return i;
        return -1;
    endfunction

    // Apply one request to the copy and return the result items it causes
    function automatic void table_apply(t_row r, ref t_res res_q[$]);
        int            idx;
        krt_pkg::t_rec tmp;
        t_res          one;
        res_q = {};
        one = '{status: krt_pkg::ST_OK, rec: NO_REC, last: 1'b1};
        idx = shadow_find(r.key);
        case (r.func)
            krt_pkg::FUNC_INSERT: begin
                if (shadow_cnt >= krt_pkg::CAPACITY) begin
                    one.status = krt_pkg::ST_FULL;
                end else if (idx >= 0) begin
                    one.status = krt_pkg::ST_DUP;
                end else begin
                    shadow_tbl[shadow_cnt] = '{r.key, r.day, r.month, r.year, r.credits};
                    shadow_cnt++;
                end
                res_q.push_back(one);
            end
            krt_pkg::FUNC_UPDATE: begin
                if (idx < 0) begin
                    one.status = krt_pkg::ST_NOTFOUND;
                end else begin
                    shadow_tbl[idx].day     = r.day;
                    shadow_tbl[idx].month   = r.month;
                    shadow_tbl[idx].year    = r.year;
                    shadow_tbl[idx].credits = r.credits;
                end
                res_q.push_back(one);
            end
            krt_pkg::FUNC_REMOVE: begin
                if (idx < 0) begin
                    one.status = krt_pkg::ST_NOTFOUND;
                end else begin
                    tmp = shadow_tbl[shadow_cnt - 1];
                    shadow_tbl[shadow_cnt - 1] = shadow_tbl[idx];
                    shadow_tbl[idx] = tmp;
                    shadow_cnt--;
                end
                res_q.push_back(one);
            end
            krt_pkg::FUNC_LOOKUP: begin
                if (idx < 0)
                    one.status = krt_pkg::ST_NOTFOUND;
                else
                    one.rec = shadow_tbl[idx];
                res_q.push_back(one);
            end
            krt_pkg::FUNC_LIST: begin
                if (shadow_cnt == 0) begin
                    one.status = krt_pkg::ST_EMPTY;
                    res_q.push_back(one);
                end else begin
                    // stable bubble sort, in place, though the block's own table keeps its order
                    for (int i = 0; i < shadow_cnt; i++)
                        for (int j = 0; j + 1 < shadow_cnt - i; j++)
                            if (shadow_tbl[j].key > shadow_tbl[j + 1].key) begin
                                tmp = shadow_tbl[j];
                                shadow_tbl[j] = shadow_tbl[j + 1];
                                shadow_tbl[j + 1] = tmp;
                            end
                    for (int i = 0; i < shadow_cnt; i++) begin
                        one.rec  = shadow_tbl[i];
                        one.last = (i + 1 == shadow_cnt);
                        res_q.push_back(one);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_row make_row(logic [2:0] func, logic [19:0] key, logic [4:0] day,
                                      logic [3:0] month, logic [13:0] year,
                                      logic [13:0] credits);
        t_row r;
        r = '{func, key, day, month, year, credits, 1'b0, '0};
        return r;
    endfunction

    task automatic add_row(logic [2:0] func, logic [19:0] key, logic [4:0] day,
                           logic [3:0] month, logic [13:0] year, logic [13:0] credits,
                           bit typed = 0, logic [2:0] status = krt_pkg::ST_OK,
                           krt_pkg::t_rec rec = '0);
        t_row r;
        r = make_row(func, key, day, month, year, credits);
        r.typed = typed;
        r.res   = '{status: status, rec: rec, last: 1'b1};
        stim_rows.push_back(r);
    endtask

    // Sender: offer one item after a random gap and hold it until taken
    bit send_quiet;

    task automatic send_item(t_row r);
        int   gap;
        t_res res_q[$];
        if ($urandom_range(0, 19) == 0)
            send_quiet = ~send_quiet;
        gap = send_quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_func    <= r.func;
        i_key     <= r.key;
        i_day     <= r.day;
        i_month   <= r.month;
        i_year    <= r.year;
        i_credits <= r.credits;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        table_apply(r, res_q);
        if (r.typed) begin
            if (res_q.size() > 0)
                pending_results.push_back(r.res);
        end else begin
            foreach (res_q[k])
                pending_results.push_back(res_q[k]);
        end
    endtask

    function automatic logic [19:0] pick_key(int known_pct);
        if (shadow_cnt > 0 && $urandom_range(0, 99) < known_pct)
            return shadow_tbl[$urandom_range(0, shadow_cnt - 1)].key;
        case ($urandom_range(0, 9))
            0:       return 20'h00000;
            1:       return 20'hFFFFF;
            default: return 20'($urandom_range(0, 20'hFFFFF));
        endcase
    endfunction

    function automatic t_row random_row(logic [2:0] func, int known_pct);
        return make_row(func, pick_key(known_pct), 5'($urandom_range(0, 31)),
                        4'($urandom_range(0, 15)), 14'($urandom_range(0, 16383)),
                        14'($urandom_range(0, 16383)));
    endfunction

    initial begin
        int            pick;
        t_row          r;
        krt_pkg::t_rec rec_hi;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_func    <= krt_pkg::FUNC_INSERT;
        i_key     <= '0;
        i_day     <= '0;
        i_month   <= '0;
        i_year    <= '0;
        i_credits <= '0;
        error_count = 0;
        shadow_cnt  = 0;
        send_quiet  = 0;
        reset_done  = 0;

        rec_hi = '{20'hFFFFF, 5'd31, 4'd15, 14'h3FFF, 14'h3FFF};
        add_row(krt_pkg::FUNC_LOOKUP, 20'd0, 0, 0, 0, 0, 1, krt_pkg::ST_NOTFOUND);
        add_row(krt_pkg::FUNC_LIST,   20'd0, 0, 0, 0, 0, 1, krt_pkg::ST_EMPTY);
        add_row(krt_pkg::FUNC_UPDATE, 20'd5, 1, 1, 1, 1, 1, krt_pkg::ST_NOTFOUND);
        add_row(krt_pkg::FUNC_REMOVE, 20'd5, 0, 0, 0, 0, 1, krt_pkg::ST_NOTFOUND);
        add_row(krt_pkg::FUNC_INSERT, 20'd0, 0, 0, 0, 0, 1, krt_pkg::ST_OK);
        add_row(krt_pkg::FUNC_INSERT, 20'hFFFFF, 31, 15, 14'h3FFF, 14'h3FFF, 1,
                krt_pkg::ST_OK);
        add_row(krt_pkg::FUNC_INSERT, 20'd0, 7, 7, 7, 7, 1, krt_pkg::ST_DUP);
        add_row(krt_pkg::FUNC_LOOKUP, 20'hFFFFF, 0, 0, 0, 0, 1, krt_pkg::ST_OK, rec_hi);
        add_row(krt_pkg::FUNC_LOOKUP, 20'd0, 0, 0, 0, 0, 1, krt_pkg::ST_OK, NO_REC);
        add_row(krt_pkg::FUNC_INSERT, 20'd999999, 15, 12, 9999, 9999, 1, krt_pkg::ST_OK);
        add_row(krt_pkg::FUNC_INSERT, 20'd500, 3, 6, 1987, 120);
        add_row(krt_pkg::FUNC_LIST,   20'd0, 0, 0, 0, 0);
        add_row(krt_pkg::FUNC_UPDATE, 20'd0, 31, 12, 2024, 77, 1, krt_pkg::ST_OK);
        add_row(krt_pkg::FUNC_LOOKUP, 20'd0, 0, 0, 0, 0);
        add_row(krt_pkg::FUNC_REMOVE, 20'hFFFFF, 0, 0, 0, 0, 1, krt_pkg::ST_OK);
        add_row(krt_pkg::FUNC_LOOKUP, 20'hFFFFF, 0, 0, 0, 0, 1, krt_pkg::ST_NOTFOUND);
        add_row(3'd5, 20'd500, 1, 1, 1, 1);
        add_row(3'd6, 20'd0, 0, 0, 0, 0);
        add_row(3'd7, 20'hFFFFF, 31, 15, 14'h3FFF, 14'h3FFF);
        add_row(krt_pkg::FUNC_LIST,   20'd0, 0, 0, 0, 0);
        add_row(krt_pkg::FUNC_REMOVE, 20'd0, 0, 0, 0, 0, 1, krt_pkg::ST_OK);
        add_row(krt_pkg::FUNC_UPDATE, 20'd999999, 1, 2, 3, 4, 1, krt_pkg::ST_OK);
        add_row(krt_pkg::FUNC_LIST,   20'd0, 0, 0, 0, 0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        reset_done = 1;
        @(posedge i_clk);

        foreach (stim_rows[n])
            send_item(stim_rows[n]);

        // fill to capacity, mostly fresh keys, then push against the full table
        while (shadow_cnt < krt_pkg::CAPACITY)
            send_item(random_row(krt_pkg::FUNC_INSERT, 15));
        send_item(random_row(krt_pkg::FUNC_INSERT, 0));
        send_item(random_row(krt_pkg::FUNC_INSERT, 100));
        send_item(random_row(krt_pkg::FUNC_LIST, 0));

        for (int n = 0; n < RANDOM_ITEMS; ) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                r = random_row(krt_pkg::FUNC_INSERT, 25);
            else if (pick < 50)
                r = random_row(krt_pkg::FUNC_UPDATE, 75);
            else if (pick < 70)
                r = random_row(krt_pkg::FUNC_REMOVE, 75);
            else if (pick < 90)
                r = random_row(krt_pkg::FUNC_LOOKUP, 75);
            else if (pick < 95)
                r = random_row(krt_pkg::FUNC_LIST, 0);
            else
                r = random_row(3'($urandom_range(5, 7)), 50);
            send_item(r);
            if (r.func <= krt_pkg::FUNC_LIST)
                n++;
        end
        i_valid <= 1'b0;

        while (pending_results.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("tb_keyed_record_table_unit: PASS");
        else
            $display("tb_keyed_record_table_unit: FAIL");
        $finish;
    end

    // Receiver: random stalls, one long hold-off to back the block up
    initial begin
        int   gap;
        bit   quiet;
        t_res want;
        t_res got;
        i_ready <= 1'b0;
        result_count = 0;
        quiet = 0;
        wait (reset_done);
        forever begin
            if ($urandom_range(0, 19) == 0)
                quiet = ~quiet;
            gap = quiet ? 0 : $urandom_range(0, 4);
            if (result_count == 40)
                gap = HOLD_CYCLES;
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid)
                @(posedge i_clk);
            result_count++;
            got = '{o_status, '{o_rec_key, o_rec_day, o_rec_month, o_rec_year,
                    o_rec_credits}, o_last};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result item, actual %p", $time, got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, got.status);
                    error_count++;
                end
                if (got.rec.key !== want.rec.key) begin
                    $display("%0t: rec_key expected %0d actual %0d", $time,
                             want.rec.key, got.rec.key);
                    error_count++;
                end
                if (got.rec.day !== want.rec.day) begin
                    $display("%0t: rec_day expected %0d actual %0d", $time,
                             want.rec.day, got.rec.day);
                    error_count++;
                end
                if (got.rec.month !== want.rec.month) begin
                    $display("%0t: rec_month expected %0d actual %0d", $time,
                             want.rec.month, got.rec.month);
                    error_count++;
                end
                if (got.rec.year !== want.rec.year) begin
                    $display("%0t: rec_year expected %0d actual %0d", $time,
                             want.rec.year, got.rec.year);
                    error_count++;
                end
                if (got.rec.credits !== want.rec.credits) begin
                    $display("%0t: rec_credits expected %0d actual %0d", $time,
                             want.rec.credits, got.rec.credits);
                    error_count++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last expected %0d actual %0d", $time,
                             want.last, got.last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #120ms;
        $display("tb_keyed_record_table_unit: FAIL");
        $finish;
    end

endmodule
